// ----- hdl/ffa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and controller/datapath interface types for the
// first-fit free-list heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // Default heap depth in bytes; power of two, 64 to 65536.
  localparam int unsigned HEAP_MAX_BYTES = 4096;
  // Allocation granule; power of two, 1 to 16.
  localparam int unsigned ALIGN_BYTES    = 4;
  // Size of one block header in bytes, 4 to 32.
  localparam int unsigned HEADER_BYTES   = 8;

  localparam int unsigned REQ_W  = 13;
  localparam int unsigned OFF_W  = 12;
  localparam int unsigned HEAP_W = 13;

  localparam logic [HEAP_W-1:0] HEAP_RESET = 13'd4096;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the request, start the walk at the list head
    logic walk;      // step to the next header on the list
    logic take;      // latch the fitting header and the split decision
    logic upd_wr;    // shrink the taken block, relink its predecessor
    logic split_wr;  // write the remainder header
    logic fmt_wr;    // write the single free block of a fresh heap
    logic free_wr;   // push a freed block onto the list head
    logic report;    // drive a result next cycle
    logic hit;       // the result is a grant
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic head_ok;   // free list is not empty
    logic free_ok;   // free offset lies past the first header
    logic fit;       // header under test is large enough
    logic split;     // taken block leaves room for another block
    logic last;      // header under test ends the walk
  } status_t;

endpackage

// ----- hdl/first_fit_heap_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit free-list heap allocator with headers held in on-chip memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A free completes at
// acceptance and returns no result. An allocate returns one result, shown on
// granted/data_offset for the single cycle that done is high; the receiver
// cannot stall it. The walk examines one header per cycle out of the header
// memory's registered read port. When a header on the free list is the first
// that fits, the controller passes through its update state, and through its
// split state as well when the chosen block is split, before the result. When
// the list ends, or the walk gives up on a looped list, the result follows the
// last header examined; a looped list is abandoned after HEAP_MAX_BYTES
// headers. An empty list answers in the next cycle. The next request can be
// taken in the cycle that carries the result. After reset and after every
// heap_bytes write the block formats the heap, with busy high.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_MAX_BYTES = ffa_pkg::HEAP_MAX_BYTES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind,
  input  logic [ffa_pkg::REQ_W-1:0]  request_bytes,
  input  logic [ffa_pkg::OFF_W-1:0]  block_offset,
  output logic                       done,
  output logic                       granted,
  output logic [ffa_pkg::OFF_W-1:0]  data_offset,
  input  logic                       heap_bytes_we,
  input  logic [ffa_pkg::HEAP_W-1:0] heap_bytes_wdata
);

  ffa_pkg::cmd_t    cmd;
  ffa_pkg::status_t status;

  ffa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .kind          (kind),
    .heap_bytes_we (heap_bytes_we),
    .status        (status),
    .cmd           (cmd),
    .busy          (busy)
  );

  ffa_datapath #(
    .HEAP_MAX_BYTES (HEAP_MAX_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .heap_bytes_we    (heap_bytes_we),
    .heap_bytes_wdata (heap_bytes_wdata),
    .request_bytes    (request_bytes),
    .block_offset     (block_offset),
    .done             (done),
    .granted          (granted),
    .data_offset      (data_offset)
  );

  // A result only follows an accepted request or work in progress.
  a_done_cause : assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a request");

  // A refused allocate carries a zero offset.
  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    (done && !granted) |-> (data_offset == '0))
    else $error("refused allocate with nonzero offset");

  // A heap size write makes the block busy while it reformats.
  a_fmt_busy : assert property (@(posedge clk) disable iff (rst)
    heap_bytes_we |=> busy)
    else $error("no reformat after heap size write");

  // A free returns no result.
  a_free_silent : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind == ffa_pkg::KIND_FREE)) |=> !done)
    else $error("result after a free");

endmodule

// ----- hdl/ffa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for the allocator: heap formatting, free-list push, and the
// first-fit walk with its split and unlink steps.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             kind,
  input  logic             heap_bytes_we,
  input  ffa_pkg::status_t status,
  output ffa_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FORMAT = 5'b00010,
    S_CHECK  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_SPLIT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   fmt_pending;
  logic   fmt_pending_next;

  assign busy = (state != S_IDLE) | fmt_pending;

  // Reformat is owed after reset and after every heap size write.
  assign fmt_pending_next = heap_bytes_we | (fmt_pending & (state != S_FORMAT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fmt_pending <= 1'b1;
    end else begin
      state       <= state_next;
      fmt_pending <= fmt_pending_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (fmt_pending) begin
          state_next = S_FORMAT;
        end else if (start) begin
          if (kind == ffa_pkg::KIND_FREE) begin
            cmd.free_wr = status.free_ok;
          end else begin
            cmd.load = 1'b1;
            if (status.head_ok) begin
              state_next = S_CHECK;
            end else begin
              cmd.report = 1'b1;
            end
          end
        end
      end
      S_FORMAT: begin
        cmd.fmt_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_CHECK: begin
        if (status.fit) begin
          cmd.take   = 1'b1;
          state_next = S_UPDATE;
        end else if (status.last) begin
          cmd.report = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      S_UPDATE: begin
        cmd.upd_wr = 1'b1;
        if (status.split) begin
          state_next = S_SPLIT;
        end else begin
          cmd.report = 1'b1;
          cmd.hit    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SPLIT: begin
        cmd.split_wr = 1'b1;
        cmd.report   = 1'b1;
        cmd.hit      = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/ffa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_datapath
// Header store (size and link memories), list head, walk registers and the
// result register of the allocator.
// ----------------------------------------------------------------------------
module ffa_datapath #(
  parameter int unsigned HEAP_MAX_BYTES = ffa_pkg::HEAP_MAX_BYTES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ffa_pkg::cmd_t              cmd,
  output ffa_pkg::status_t           status,
  input  logic                       heap_bytes_we,
  input  logic [ffa_pkg::HEAP_W-1:0] heap_bytes_wdata,
  input  logic [ffa_pkg::REQ_W-1:0]  request_bytes,
  input  logic [ffa_pkg::OFF_W-1:0]  block_offset,
  output logic                       done,
  output logic                       granted,
  output logic [ffa_pkg::OFF_W-1:0]  data_offset
);

  localparam int unsigned AW = $clog2(HEAP_MAX_BYTES);
  // Wide enough for rounded requests plus header and granule, and any size.
  localparam int unsigned NW = ((AW > 14) ? AW : 14) + 1;
  // Wide enough for a header offset plus header bytes.
  localparam int unsigned OW = ((AW > ffa_pkg::OFF_W) ? AW : ffa_pkg::OFF_W) + 1;
  // Wide enough for the heap size register and the heap depth.
  localparam int unsigned TW = ((AW > ffa_pkg::HEAP_W) ? AW : ffa_pkg::HEAP_W) + 1;

  localparam logic [NW-1:0] ALIGN_M1  = NW'(ffa_pkg::ALIGN_BYTES - 1);
  localparam logic [NW-1:0] HDR_N     = NW'(ffa_pkg::HEADER_BYTES);
  localparam logic [NW-1:0] HDR_ALIGN = NW'(ffa_pkg::HEADER_BYTES + ffa_pkg::ALIGN_BYTES);
  localparam logic [TW-1:0] HDR_T     = TW'(ffa_pkg::HEADER_BYTES);
  localparam logic [TW-1:0] HEAP_T    = TW'(HEAP_MAX_BYTES);

  logic [AW-1:0] size_mem [HEAP_MAX_BYTES];
  logic [AW:0]   link_mem [HEAP_MAX_BYTES];

  logic [ffa_pkg::HEAP_W-1:0] heap_bytes;
  logic [AW-1:0] list_head;
  logic          head_ok;

  logic [NW-1:0] need;
  logic [NW-1:0] need_h;
  logic [NW-1:0] need_split;
  logic [AW-1:0] cur;
  logic [AW-1:0] prev;
  logic          prev_ok;
  logic [AW-1:0] cnt;

  logic [AW-1:0] rd_size;
  logic [AW-1:0] rd_link;
  logic          rd_ok;
  logic [AW-1:0] rd_addr;

  logic          split_r;
  logic [AW-1:0] rem;
  logic [AW-1:0] nb;
  logic [AW-1:0] lk_r;
  logic          lk_ok_r;

  logic [NW-1:0] need_c;
  logic [NW-1:0] sz_ext;
  logic [TW-1:0] total;
  logic [AW-1:0] fmt_size;
  logic [TW-1:0] free_hdr;
  logic [AW-1:0] free_h;
  logic [AW-1:0] succ;
  logic          succ_ok;
  logic [OW-1:0] offset_c;

  // Round up to the granule; the granule is a power of two.
  assign need_c = (NW'(request_bytes) + ALIGN_M1) & ~ALIGN_M1;

  assign total    = (TW'(heap_bytes) > HEAP_T) ? HEAP_T : TW'(heap_bytes);
  assign fmt_size = (total > HDR_T) ? AW'(total - HDR_T) : '0;

  assign free_hdr = TW'(block_offset) - HDR_T;
  assign free_h   = free_hdr[AW-1:0];

  assign sz_ext   = NW'(rd_size);
  assign succ     = split_r ? nb : lk_r;
  assign succ_ok  = split_r | lk_ok_r;
  assign offset_c = OW'(cur) + OW'(ffa_pkg::HEADER_BYTES);

  assign rd_addr = cmd.walk ? rd_link : list_head;

  assign status.head_ok = head_ok;
  assign status.free_ok = block_offset >= ffa_pkg::OFF_W'(ffa_pkg::HEADER_BYTES);
  assign status.fit     = sz_ext >= need;
  assign status.split   = split_r;
  assign status.last    = ~rd_ok | (&cnt);

  // Header store: one write per memory per cycle, registered read.
  always_ff @(posedge clk) begin
    if (cmd.fmt_wr) begin
      size_mem[AW'(0)] <= fmt_size;
      link_mem[AW'(0)] <= '0;
    end else if (cmd.upd_wr) begin
      if (split_r) begin
        size_mem[cur] <= need[AW-1:0];
      end
      if (prev_ok) begin
        link_mem[prev] <= {succ_ok, succ};
      end
    end else if (cmd.split_wr) begin
      size_mem[nb] <= rem;
      // A predecessor sitting on the remainder header keeps its relink.
      link_mem[nb] <= (prev_ok && (prev == nb)) ? {1'b1, nb} : {lk_ok_r, lk_r};
    end else if (cmd.free_wr) begin
      link_mem[free_h] <= {head_ok, list_head};
    end
    rd_size           <= size_mem[rd_addr];
    {rd_ok, rd_link}  <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_bytes <= ffa_pkg::HEAP_RESET;
      list_head  <= '0;
      head_ok    <= 1'b1;
      done       <= 1'b0;
    end else begin
      if (heap_bytes_we) begin
        heap_bytes <= heap_bytes_wdata;
      end
      if (cmd.fmt_wr) begin
        list_head <= '0;
        head_ok   <= 1'b1;
      end else if (cmd.free_wr) begin
        list_head <= free_h;
        head_ok   <= 1'b1;
      end else if (cmd.upd_wr && !prev_ok) begin
        list_head <= succ;
        head_ok   <= succ_ok;
      end
      done <= cmd.report;
    end
  end

  // Walk registers and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      need       <= need_c;
      need_h     <= need_c + HDR_N;
      need_split <= need_c + HDR_ALIGN;
      cur        <= list_head;
      prev_ok    <= 1'b0;
      cnt        <= '0;
    end
    if (cmd.walk) begin
      prev    <= cur;
      prev_ok <= 1'b1;
      cur     <= rd_link;
      cnt     <= cnt + AW'(1);
    end
    if (cmd.take) begin
      split_r <= sz_ext >= need_split;
      rem     <= AW'(sz_ext - need_h);
      nb      <= AW'(NW'(cur) + need_h);
      lk_r    <= rd_link;
      lk_ok_r <= rd_ok;
    end
    if (cmd.report) begin
      granted     <= cmd.hit;
      data_offset <= cmd.hit ? offset_c[ffa_pkg::OFF_W-1:0] : '0;
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit heap allocator. A scoreboard object
// keeps its own copy of the header store and free list, predicts the grant
// for every accepted allocate, and compares it with each result strobe.
// Directed requests cover the corner cases, then random alloc/free traffic
// runs over several heap sizes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT = 4000000;

  typedef struct {
    bit                        granted;
    logic [ffa_pkg::OFF_W-1:0] offset;
  } grant_t;

  class grant_scoreboard;
    int unsigned blk_size    [ffa_pkg::HEAP_MAX_BYTES];
    int unsigned blk_link    [ffa_pkg::HEAP_MAX_BYTES];
    bit          blk_link_ok [ffa_pkg::HEAP_MAX_BYTES];
    int unsigned head;
    bit          head_ok;
    grant_t      expected_grants[$];
    grant_t      last_grant;
    int unsigned errors;

    function new();
      errors = 0;
      reformat(ffa_pkg::HEAP_RESET);
    endfunction

    // Rebuild the heap as one free block at offset zero.
    function void reformat(int unsigned heap);
      int unsigned total;
      total = (heap > ffa_pkg::HEAP_MAX_BYTES) ? ffa_pkg::HEAP_MAX_BYTES : heap;
      blk_size[0]    = (total > ffa_pkg::HEADER_BYTES) ? total - ffa_pkg::HEADER_BYTES : 0;
      blk_link[0]    = 0;
      blk_link_ok[0] = 1'b0;
      head           = 0;
      head_ok        = 1'b1;
    endfunction

    function grant_t first_fit_alloc(logic [ffa_pkg::REQ_W-1:0] req);
      grant_t      res;
      int unsigned need, cur, prev, sz, nxt, nb, succ, n;
      bit          nxt_ok, prev_ok, succ_ok;
      res.granted = 1'b0;
      res.offset  = '0;
      need = ((req + ffa_pkg::ALIGN_BYTES - 1) / ffa_pkg::ALIGN_BYTES)
             * ffa_pkg::ALIGN_BYTES;
      cur = head;
      prev = 0;
      prev_ok = 1'b0;
      if (head_ok) begin
        // Walk is bounded so a looped list reports no fit.
        for (n = 0; n < ffa_pkg::HEAP_MAX_BYTES; n++) begin
          sz     = blk_size[cur];
          nxt    = blk_link[cur];
          nxt_ok = blk_link_ok[cur];
          if (sz >= need) begin
            if (sz - need >= ffa_pkg::HEADER_BYTES + ffa_pkg::ALIGN_BYTES) begin
              nb = (cur + ffa_pkg::HEADER_BYTES + need) % ffa_pkg::HEAP_MAX_BYTES;
              blk_size[cur]   = need;
              blk_size[nb]    = sz - need - ffa_pkg::HEADER_BYTES;
              blk_link[nb]    = nxt;
              blk_link_ok[nb] = nxt_ok;
              succ    = nb;
              succ_ok = 1'b1;
            end else begin
              succ    = nxt;
              succ_ok = nxt_ok;
            end
            if (prev_ok) begin
              blk_link[prev]    = succ;
              blk_link_ok[prev] = succ_ok;
            end else begin
              head    = succ;
              head_ok = succ_ok;
            end
            res.granted = 1'b1;
            res.offset  = ffa_pkg::OFF_W'(cur + ffa_pkg::HEADER_BYTES);
            return res;
          end
          if (!nxt_ok) break;
          prev    = cur;
          prev_ok = 1'b1;
          cur     = nxt % ffa_pkg::HEAP_MAX_BYTES;
        end
      end
      return res;
    endfunction

    function void note_request(logic k, logic [ffa_pkg::REQ_W-1:0] req,
                               logic [ffa_pkg::OFF_W-1:0] off);
      int unsigned h;
      if (k == ffa_pkg::KIND_FREE) begin
        // Push onto the list head; offsets inside the first header are dropped.
        if (off >= ffa_pkg::HEADER_BYTES) begin
          h = (off - ffa_pkg::HEADER_BYTES) % ffa_pkg::HEAP_MAX_BYTES;
          blk_link[h]    = head;
          blk_link_ok[h] = head_ok;
          head           = h;
          head_ok        = 1'b1;
        end
      end else begin
        last_grant = first_fit_alloc(req);
        expected_grants.push_back(last_grant);
      end
    endfunction

    function void check_result(logic g, logic [ffa_pkg::OFF_W-1:0] off);
      grant_t exp_grant;
      if (expected_grants.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with no request pending: granted=%0d offset=%0d", g, off);
        return;
      end
      exp_grant = expected_grants.pop_front();
      if (g !== exp_grant.granted || off !== exp_grant.offset) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: expected granted=%0d offset=%0d, got granted=%0d offset=%0d",
                   exp_grant.granted, exp_grant.offset, g, off);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst              = 1'b1;
  logic                       start            = 1'b0;
  logic                       busy;
  logic                       kind             = ffa_pkg::KIND_ALLOC;
  logic [ffa_pkg::REQ_W-1:0]  request_bytes    = '0;
  logic [ffa_pkg::OFF_W-1:0]  block_offset     = '0;
  logic                       done;
  logic                       granted;
  logic [ffa_pkg::OFF_W-1:0]  data_offset;
  logic                       heap_bytes_we    = 1'b0;
  logic [ffa_pkg::HEAP_W-1:0] heap_bytes_wdata = ffa_pkg::HEAP_RESET;

  grant_scoreboard            sb;
  logic [ffa_pkg::OFF_W-1:0]  live_blocks[$];
  logic [ffa_pkg::OFF_W-1:0]  last_offset;
  int unsigned                cycle_count = 0;

  first_fit_heap_allocator dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .kind             (kind),
    .request_bytes    (request_bytes),
    .block_offset     (block_offset),
    .done             (done),
    .granted          (granted),
    .data_offset      (data_offset),
    .heap_bytes_we    (heap_bytes_we),
    .heap_bytes_wdata (heap_bytes_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(granted, data_offset);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("first_fit_heap_allocator: mismatch");
      $finish;
    end
  end

  // Hold the request until the block takes it; start stays high afterwards.
  task automatic send_request(input logic k, input logic [ffa_pkg::REQ_W-1:0] req,
                              input logic [ffa_pkg::OFF_W-1:0] off);
    start         <= 1'b1;
    kind          <= k;
    request_bytes <= req;
    block_offset  <= off;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(k, req, off);
    if (k == ffa_pkg::KIND_ALLOC) begin
      last_offset = sb.last_grant.offset;
      if (sb.last_grant.granted) live_blocks.push_back(sb.last_grant.offset);
    end
  endtask

  task automatic alloc_req(input int unsigned req);
    send_request(ffa_pkg::KIND_ALLOC, ffa_pkg::REQ_W'(req), ffa_pkg::OFF_W'($urandom));
  endtask

  task automatic free_req(input logic [ffa_pkg::OFF_W-1:0] off);
    send_request(ffa_pkg::KIND_FREE, ffa_pkg::REQ_W'($urandom), off);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Write heap_bytes only once the block has drained.
  task automatic write_heap_size(input int unsigned heap);
    start <= 1'b0;
    while (sb.expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    heap_bytes_we    <= 1'b1;
    heap_bytes_wdata <= ffa_pkg::HEAP_W'(heap);
    sb.reformat(heap & 13'h1FFF);
    live_blocks.delete();
    @(posedge clk);
    heap_bytes_we    <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned heap, input int unsigned n_items,
                           input bit idle_on);
    int unsigned               sent, cap, pick, r, req;
    logic [ffa_pkg::OFF_W-1:0] off;
    write_heap_size(heap);
    cap  = (heap > ffa_pkg::HEAP_MAX_BYTES) ? ffa_pkg::HEAP_MAX_BYTES : heap;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // Noise: offset inside the first header, the block drops it.
        free_req(ffa_pkg::OFF_W'($urandom_range(0, ffa_pkg::HEADER_BYTES - 1)));
      end else begin
        if (r < 45 && live_blocks.size() > 0) begin
          pick = $urandom_range(0, live_blocks.size() - 1);
          off  = live_blocks[pick];
          live_blocks.delete(pick);
          free_req(off);
        end else begin
          r = $urandom_range(0, 9);
          if (r == 0)     req = $urandom_range(0, 8191);
          else if (r < 3) req = $urandom_range(0, cap);
          else            req = $urandom_range(0, (cap < 64) ? cap : 64);
          alloc_req(req);
        end
        sent++;
      end
      if (idle_on && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 13));
    end
  endtask

  initial begin
    logic [ffa_pkg::OFF_W-1:0] a_off, c_off, d_off, x_off;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Heap as formatted by reset.
    alloc_req(0);
    a_off = last_offset;
    alloc_req(1);
    alloc_req(8191);
    alloc_req(4096);
    free_req(0);
    free_req(7);
    alloc_req(13);
    c_off = last_offset;
    alloc_req(40);
    d_off = last_offset;
    alloc_req(16);
    free_req(d_off);
    free_req(c_off);
    // Skip the small head block, take the exact fit whole from mid-list.
    alloc_req(40);
    // Split the remainder behind the small head block.
    alloc_req(24);
    alloc_req(16);
    free_req(a_off);
    alloc_req(0);

    // Heap no larger than one header: one empty block, then an empty list.
    write_heap_size(ffa_pkg::HEADER_BYTES);
    alloc_req(0);
    alloc_req(0);

    // Oversized heap clamps to the maximum.
    write_heap_size(8191);
    alloc_req(ffa_pkg::HEAP_MAX_BYTES - ffa_pkg::HEADER_BYTES);
    alloc_req(1);

    // Double free loops the list; an unfit request must give up.
    write_heap_size(4096);
    alloc_req(100);
    x_off = last_offset;
    free_req(x_off);
    free_req(x_off);
    alloc_req(200);

    run_phase(4096, 400, 1'b1);
    run_phase(12, 20, 1'b1);
    run_phase($urandom_range(13, 4096), 350, 1'b1);
    run_phase($urandom_range(12, 160), 250, 1'b1);
    run_phase(0, 10, 1'b0);
    run_phase(8191, 300, 1'b1);
    run_phase($urandom_range(2048, 8191), 250, 1'b0);
    run_phase(4096, 300, 1'b0);

    start <= 1'b0;
    while (sb.expected_grants.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("first_fit_heap_allocator: match");
    end else begin
      $display("first_fit_heap_allocator: mismatch");
    end
    $finish;
  end

endmodule
